// ===== rtl/vdm_pkg.sv =====
`timescale 1ns / 1ps
package vdm_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  // signed width of the moment terms and their magnitudes
  localparam int VW       = 53;
  localparam int MW       = VW - 1;
  localparam int PW       = 2 * MW;
  localparam int RW       = MW + 4;
  localparam int DVW      = MW + 16;
  localparam int ONE_Q16  = 65536;

  typedef enum logic [1:0] {
    MODE_EUCLID = 2'd0,
    MODE_COSINE = 2'd1,
    MODE_CORR   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_ACC,
    S_EVAL,
    S_MUL,
    S_CHECK,
    S_SQRT,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    M_NXX,
    M_XX,
    M_NYY,
    M_YY,
    M_NXY,
    M_XY,
    M_XXYY,
    M_VV
  } msel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DEGEN,
    RES_ROOT,
    RES_RATIO
  } res_t;

  typedef struct packed {
    logic  acc_en;
    logic  clr;
    logic  mul_start;
    msel_t msel;
    logic  sqrt_start;
    logic  sqrt_euclid;
    logic  div_start;
    logic  div_cos;
    logic  out_load;
    res_t  res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic mag_zero;
    logic var_bad;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/vdm_ctrl.sv =====
`timescale 1ns / 1ps
module vdm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       metric_mode,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             last_elem,
  input  vdm_pkg::dp_sts_t sts,
  output vdm_pkg::dp_cmd_t cmd
);
  import vdm_pkg::*;

  state_t state, state_next;
  msel_t  msel, msel_next;
  mode_t  mode, mode_l, mode_l_next;
  logic   acc;

  assign in_stall = (state != S_ACC);
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_ACC;
      msel   <= M_NXX;
      mode   <= MODE_EUCLID;
      mode_l <= MODE_EUCLID;
    end else begin
      state  <= state_next;
      msel   <= msel_next;
      mode_l <= mode_l_next;
      if (cfg_we) mode <= mode_t'(metric_mode);
    end
  end

  always_comb begin
    state_next  = state;
    msel_next   = msel;
    mode_l_next = mode_l;
    cmd         = '0;
    cmd.acc_en  = acc;
    cmd.div_cos = (mode_l == MODE_COSINE);
    unique case (state)
      S_ACC: begin
        if (acc && last_elem) begin
          state_next  = S_EVAL;
          mode_l_next = mode;
        end
      end
      S_EVAL: begin
        unique case (mode_l)
          MODE_EUCLID: begin
            cmd.sqrt_start  = 1'b1;
            cmd.sqrt_euclid = 1'b1;
            state_next      = S_SQRT;
          end
          MODE_COSINE: begin
            if (sts.mag_zero) begin
              state_next = S_DONE;
            end else begin
              cmd.mul_start = 1'b1;
              cmd.msel      = M_XXYY;
              msel_next     = M_XXYY;
              state_next    = S_MUL;
            end
          end
          MODE_CORR: begin
            cmd.mul_start = 1'b1;
            cmd.msel      = M_NXX;
            msel_next     = M_NXX;
            state_next    = S_MUL;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MUL: begin
        if (sts.mul_done) begin
          unique case (msel)
            M_NXX: begin cmd.mul_start = 1'b1; cmd.msel = M_XX;  msel_next = M_XX;  end
            M_XX:  begin cmd.mul_start = 1'b1; cmd.msel = M_NYY; msel_next = M_NYY; end
            M_NYY: begin cmd.mul_start = 1'b1; cmd.msel = M_YY;  msel_next = M_YY;  end
            M_YY:  begin cmd.mul_start = 1'b1; cmd.msel = M_NXY; msel_next = M_NXY; end
            M_NXY: begin cmd.mul_start = 1'b1; cmd.msel = M_XY;  msel_next = M_XY;  end
            M_XY:  state_next = S_CHECK;
            default: begin
              cmd.sqrt_start = 1'b1;
              state_next     = S_SQRT;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (sts.var_bad) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.msel      = M_VV;
          msel_next     = M_VV;
          state_next    = S_MUL;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          if (mode_l == MODE_EUCLID) begin
            state_next = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        priority if (mode_l == MODE_EUCLID) cmd.res_sel = RES_ROOT;
        else if (mode_l == MODE_NONE)       cmd.res_sel = RES_ZERO;
        else if (mode_l == MODE_COSINE && sts.mag_zero) cmd.res_sel = RES_DEGEN;
        else if (mode_l == MODE_CORR && sts.var_bad)    cmd.res_sel = RES_DEGEN;
        else                                            cmd.res_sel = RES_RATIO;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clr      = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

endmodule

// ===== rtl/vdm_dp.sv =====
`timescale 1ns / 1ps
module vdm_dp (
  input  logic               clk,
  input  logic               rst,
  input  vdm_pkg::dp_cmd_t   cmd,
  output vdm_pkg::dp_sts_t   sts,
  input  logic signed [15:0] x_elem,
  input  logic signed [15:0] y_elem,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        distance,
  output logic               degenerate
);
  import vdm_pkg::*;

  // running sums
  logic signed [26:0] sum_x, sum_y;
  logic signed [42:0] sum_xy;
  logic [41:0]        sum_xx, sum_yy;
  logic [44:0]        sum_diff_sq;
  logic [CNT_W-1:0]   elem_count;

  logic signed [31:0] pxy, pxx, pyy;
  logic signed [16:0] dxy;
  logic signed [33:0] dsq;

  assign pxy = x_elem * y_elem;
  assign pxx = x_elem * x_elem;
  assign pyy = y_elem * y_elem;
  assign dxy = {x_elem[15], x_elem} - {y_elem[15], y_elem};
  assign dsq = dxy * dxy;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      sum_x       <= '0;
      sum_y       <= '0;
      sum_xy      <= '0;
      sum_xx      <= '0;
      sum_yy      <= '0;
      sum_diff_sq <= '0;
      elem_count  <= '0;
    end else if (cmd.acc_en && (elem_count < CNT_W'(MAX_LEN))) begin
      sum_x       <= sum_x + 27'(x_elem);
      sum_y       <= sum_y + 27'(y_elem);
      sum_xy      <= sum_xy + 43'(pxy);
      sum_xx      <= sum_xx + {10'b0, pxx};
      sum_yy      <= sum_yy + {10'b0, pyy};
      sum_diff_sq <= sum_diff_sq + {11'b0, dsq};
      elem_count  <= elem_count + 1'b1;
    end
  end

  // shift-add multiplier, one multiplier bit a cycle, then a write-back step
  logic signed [VW-1:0] tmp, vx, vy, cxy;
  logic [PW-1:0]        sq_in;
  logic signed [VW-1:0] op_a, op_b, abs_a, abs_b;
  logic [PW-1:0]        mc, mprod, mprod_neg;
  logic [MW-1:0]        mp;
  logic                 msign, mbusy, mul_done;
  logic [6:0]           mcnt;
  msel_t                mdst;
  logic signed [VW-1:0] mres;

  always_comb begin
    unique case (cmd.msel)
      M_NXX:  begin op_a = VW'(elem_count); op_b = VW'(sum_xx); end
      M_XX:   begin op_a = VW'(sum_x);      op_b = VW'(sum_x);  end
      M_NYY:  begin op_a = VW'(elem_count); op_b = VW'(sum_yy); end
      M_YY:   begin op_a = VW'(sum_y);      op_b = VW'(sum_y);  end
      M_NXY:  begin op_a = VW'(elem_count); op_b = VW'(sum_xy); end
      M_XY:   begin op_a = VW'(sum_x);      op_b = VW'(sum_y);  end
      M_XXYY: begin op_a = VW'(sum_xx);     op_b = VW'(sum_yy); end
      default: begin op_a = vx;             op_b = vy;          end
    endcase
    abs_a = op_a[VW-1] ? -op_a : op_a;
    abs_b = op_b[VW-1] ? -op_b : op_b;
  end

  assign mprod_neg = msign ? (~mprod + 1'b1) : mprod;
  assign mres      = mprod_neg[VW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy    <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mcnt  <= 7'(MW);
        mc    <= PW'(abs_a[MW-1:0]);
        mp    <= abs_b[MW-1:0];
        mprod <= '0;
        msign <= op_a[VW-1] ^ op_b[VW-1];
        mdst  <= cmd.msel;
      end else if (mbusy) begin
        if (mcnt != 7'd0) begin
          if (mp[0]) mprod <= mprod + mc;
          mc   <= mc << 1;
          mp   <= mp >> 1;
          mcnt <= mcnt - 1'b1;
        end else begin
          mbusy    <= 1'b0;
          mul_done <= 1'b1;
          unique case (mdst)
            M_NXX, M_NYY, M_NXY: tmp <= mres;
            M_XX:                vx  <= tmp - mres;
            M_YY:                vy  <= tmp - mres;
            M_XY:                cxy <= tmp - mres;
            default:             sq_in <= mprod;
          endcase
        end
      end
    end
  end

  // restoring square root, one result bit a cycle
  logic [PW-1:0] sop;
  logic [RW-1:0] srem, srem2, strial;
  logic [MW-1:0] root;
  logic [6:0]    scnt;
  logic          sbusy, sqrt_done;

  assign srem2  = {srem[RW-3:0], sop[PW-1:PW-2]};
  assign strial = {2'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy     <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy <= 1'b1;
        scnt  <= 7'(MW);
        srem  <= '0;
        root  <= '0;
        sop   <= cmd.sqrt_euclid ? PW'({sum_diff_sq, 16'b0}) : sq_in;
      end else if (sbusy) begin
        if (srem2 >= strial) begin
          srem <= srem2 - strial;
          root <= {root[MW-2:0], 1'b1};
        end else begin
          srem <= srem2;
          root <= {root[MW-2:0], 1'b0};
        end
        sop  <= sop << 2;
        scnt <= scnt - 1'b1;
        if (scnt == 7'd1) begin
          sbusy     <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
    end
  end

  // restoring divider, |num| * 2^16 / root, one quotient bit a cycle
  logic signed [VW-1:0] dnum, dabs;
  logic [DVW-1:0]       dv, quo;
  logic [MW-1:0]        drem;
  logic [MW:0]          drem2;
  logic [6:0]           dcnt;
  logic                 dneg, dbusy, div_done;
  logic [DVW:0]         ratio_sum;
  logic [31:0]          ratio;

  assign dnum  = cmd.div_cos ? VW'(sum_xy) : cxy;
  assign dabs  = dnum[VW-1] ? -dnum : dnum;
  assign drem2 = {drem, dv[DVW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy    <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dcnt  <= 7'(DVW);
        drem  <= '0;
        quo   <= '0;
        dv    <= {dabs[MW-1:0], 16'b0};
        dneg  <= dnum[VW-1];
      end else if (dbusy) begin
        if (drem2 >= {1'b0, root}) begin
          drem <= MW'(drem2 - {1'b0, root});
          quo  <= {quo[DVW-2:0], 1'b1};
        end else begin
          drem <= drem2[MW-1:0];
          quo  <= {quo[DVW-2:0], 1'b0};
        end
        dv   <= dv << 1;
        dcnt <= dcnt - 1'b1;
        if (dcnt == 7'd1) begin
          dbusy    <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // 1 - r in Q16.16, clamped at zero and saturated
  always_comb begin
    ratio_sum = {1'b0, quo} + (DVW+1)'(ONE_Q16);
    if (dneg) begin
      ratio = (ratio_sum > (DVW+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ratio_sum[31:0];
    end else if (quo >= DVW'(ONE_Q16)) begin
      ratio = '0;
    end else begin
      ratio = 32'(ONE_Q16) - quo[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
      unique case (cmd.res_sel)
        RES_ZERO:  begin distance <= '0;          degenerate <= 1'b0; end
        RES_DEGEN: begin distance <= '0;          degenerate <= 1'b1; end
        RES_ROOT:  begin distance <= root[31:0];  degenerate <= 1'b0; end
        default:   begin distance <= ratio;       degenerate <= 1'b0; end
      endcase
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.mul_done  = mul_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.div_done  = div_done;
  assign sts.mag_zero  = (sum_xx == '0) || (sum_yy == '0);
  assign sts.var_bad   = vx[VW-1] || (vx == '0) || vy[VW-1] || (vy == '0);
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

// ===== rtl/vector_distance_metric.sv =====
`timescale 1ns / 1ps
// Distance between two vectors streamed as element pairs (signed Q8.8), one beat per
// cycle, closed by last_elem. metric_mode picks Euclidean, cosine or correlation
// distance (3 gives 0); the result is unsigned Q16.16, saturating, and degenerate
// flags zero magnitude or zero variance (distance then 0). Pairs after the first
// 1024 of a vector are ignored. Pairs are taken at one a cycle; after the last pair
// the input stalls while one shared shift-add multiplier, a bit-serial square root
// and a bit-serial divider work, as the mode needs, until the result is loaded into
// the output register, which waits for any output stall to clear.
// Write metric_mode only while the block is idle.
module vector_distance_metric (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         metric_mode,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_elem,
  input  logic signed [15:0] y_elem,
  input  logic               last_elem,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        distance,
  output logic               degenerate
);
  import vdm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accumulate, then walk the multiply / root / divide steps
  vdm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .metric_mode (metric_mode),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_elem   (last_elem),
    .sts         (sts),
    .cmd         (cmd)
  );

  // sums, iterative arithmetic and the output register
  vdm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .x_elem     (x_elem),
    .y_elem     (y_elem),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .distance   (distance),
    .degenerate (degenerate)
  );

endmodule

// ===== rtl/vdm_checker.sv =====
`timescale 1ns / 1ps
module vdm_assert (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_elem,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] distance,
  input logic        degenerate
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(degenerate))
    else $error("result beat changed while stalled");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_elem |=> in_stall)
    else $error("input not held off after last pair");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> distance == 32'd0)
    else $error("degenerate result with non-zero distance");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector_distance_metric vdm_assert u_vdm_assert (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_elem  (last_elem),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .distance   (distance),
  .degenerate (degenerate)
);
